// File: sv/crt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the clock replacement table.
package crt_pkg;

  // Default sizes handed to the top-level parameters
  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int QUEUE_DEPTH  = 2;

  // Configuration port
  localparam int CAP_BITS = 5;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic REG_ENABLE   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic                ENABLE_RST   = 1'b1;
  localparam logic [CAP_BITS-1:0] CAPACITY_RST = 5'd16;

  // Input operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_TOUCH = 1'b1;

  // What the front end decided a transaction has to do
  localparam int KIND_BITS = 2;
  typedef enum logic [KIND_BITS-1:0] {
    KIND_NOP   = 2'd0,
    KIND_TOUCH = 2'd1,
    KIND_ADD   = 2'd2
  } crt_kind_t;

  // Configuration seen by the front and back ends
  typedef struct packed {
    logic                enable;
    logic [CAP_BITS-1:0] capacity;
  } crt_cfg_t;

endpackage

// File: sv/clock_replacement_table_unit.sv
`timescale 1ns / 1ps
// Top level of the clock (second-chance) replacement table.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  in_op, in_key
//   out      output     out_valid/out_ready  out_evicted, out_victim_key, out_hit
//   config   APB        psel/penable/pready  paddr, pwdata, prdata
//
// The back end works one transaction at a time. A disabled transaction goes
// straight to commit. Touch and add scan the key RAM one key a cycle; an
// evicting add then steps the clock hand until it meets a valid, unreferenced
// entry and reads that victim's key. Reset is synchronous and clears the
// table at once. A two-entry queue accepts input, until it is full, while the
// back end is busy or its result register waits on out_ready.
module clock_replacement_table_unit #(
  parameter int DEPTH    = crt_pkg::DEPTH_DEF,
  parameter int KEY_BITS = crt_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [KEY_BITS-1:0]         in_key,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_evicted,
  output logic [KEY_BITS-1:0]         out_victim_key,
  output logic                        out_hit,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crt_pkg::CFG_AW-1:0]  paddr,
  input  logic [crt_pkg::CFG_DW-1:0]  pwdata,
  output logic [crt_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  import crt_pkg::*;

  localparam int QW = KEY_BITS + KIND_BITS;

  logic                enable_r;
  logic [CAP_BITS-1:0] capacity_r;
  logic                reg_idx;
  logic                cfg_wr;
  crt_cfg_t            cfg;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= ENABLE_RST;
      capacity_r <= CAPACITY_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ENABLE:   enable_r   <= pwdata[0];
        REG_CAPACITY: capacity_r <= pwdata[CAP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE:   prdata = {{(CFG_DW-1){1'b0}}, enable_r};
      REG_CAPACITY: prdata = {{(CFG_DW-CAP_BITS){1'b0}}, capacity_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.enable   = enable_r;
  assign cfg.capacity = capacity_r;

  crt_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_key   (in_key),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  crt_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  crt_back #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_evicted    (out_evicted),
    .out_victim_key (out_victim_key),
    .out_hit        (out_hit)
  );

endmodule

// File: sv/crt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module crt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/crt_fifo.sv
`timescale 1ns / 1ps
// Short queue between the front end and the back end.
module crt_fifo #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  // Pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: sv/crt_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies them and queues them.
module crt_front #(
  parameter int KEY_BITS = 32
) (
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_op,
  input  logic [KEY_BITS-1:0]                    in_key,
  input  crt_pkg::crt_cfg_t                      cfg,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [KEY_BITS+crt_pkg::KIND_BITS-1:0] q_wdata
);

  import crt_pkg::*;

  crt_kind_t kind;

  // A disabled table turns every transaction into a no-op
  always_comb begin
    if (!cfg.enable) begin
      kind = KIND_NOP;
    end else if (in_op == OP_TOUCH) begin
      kind = KIND_TOUCH;
    end else begin
      kind = KIND_ADD;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_wdata  = {kind, in_key};

endmodule

// File: sv/crt_back.sv
`timescale 1ns / 1ps
// Back end: key scan, clock sweep, eviction, insert and result register.
module crt_back #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  crt_pkg::crt_cfg_t                      cfg,
  input  logic                                   q_empty,
  input  logic [KEY_BITS+crt_pkg::KIND_BITS-1:0] q_rdata,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_evicted,
  output logic [KEY_BITS-1:0]                    out_victim_key,
  output logic                                   out_hit
);

  import crt_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_BITS) ? CW : CAP_BITS;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_VREAD  = 5'b01000,
    ST_COMMIT = 5'b10000
  } crt_state_t;

  crt_state_t state_r, state_nxt;

  // Table state
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [DEPTH-1:0] ref_r, ref_nxt;
  logic [IW-1:0]    hand_r, hand_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Current transaction
  logic [KEY_BITS-1:0] key_r;
  crt_kind_t           kind_r;
  logic [CW-1:0]       scan_cnt_r;
  logic                hit_r;
  logic [IW-1:0]       pos_r;
  logic                free_fnd_r;
  logic [IW-1:0]       free_idx_r;
  logic                evict_r;
  logic [IW-1:0]       vic_r;
  logic [KEY_BITS-1:0] vkey_r;

  // Result register
  logic                out_valid_r;
  logic                out_evicted_r;
  logic [KEY_BITS-1:0] out_victim_key_r;
  logic                out_hit_r;

  logic [IW-1:0]       ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;
  logic                ram_we;
  logic [IW-1:0]       ins_idx;

  crt_kind_t     pop_kind;
  logic [CW-1:0] scan_prev;
  logic [IW-1:0] chk_idx;
  logic          scan_live, scan_done, chk_match, chk_free;
  logic [IW-1:0] hand_next;
  logic          cur_valid, cur_ref, sweep_stop;
  logic [EW-1:0] cap_ext, eff_cap, cnt_ext;
  logic          need_evict;
  logic          out_free, commit, present, use_vic, do_ins;

  crt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ins_idx),
    .wdata (key_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pop_kind = crt_kind_t'(q_rdata[KEY_BITS +: KIND_BITS]);
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  // Key scan: each address is compared in the cycle after it is issued
  assign scan_prev = scan_cnt_r - CW'(1);
  assign chk_idx   = scan_prev[IW-1:0];
  assign scan_live = (scan_cnt_r != '0);
  assign scan_done = (scan_cnt_r == CW'(DEPTH));
  assign chk_match = valid_r[chk_idx] && (ram_rdata == key_r);
  assign chk_free  = !valid_r[chk_idx];

  // Clock hand
  assign hand_next  = (hand_r == IW'(DEPTH - 1)) ? '0 : hand_r + IW'(1);
  assign cur_valid  = valid_r[hand_r];
  assign cur_ref    = ref_r[hand_r];
  assign sweep_stop = cur_valid && !cur_ref;

  assign ram_raddr = (state_r == ST_SWEEP) ? hand_r : scan_cnt_r[IW-1:0];

  // Effective capacity: zero acts as one, above the depth acts as the depth
  assign cap_ext = EW'(cfg.capacity);
  assign cnt_ext = EW'(count_r);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign need_evict = (cnt_ext >= eff_cap) && (count_r != '0);

  // Commit decisions
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_COMMIT) && out_free;
  assign present  = hit_r && !(evict_r && (pos_r == vic_r));
  assign use_vic  = evict_r && (!free_fnd_r || (vic_r < free_idx_r));
  assign ins_idx  = use_vic ? vic_r : free_idx_r;
  assign do_ins   = commit && (kind_r == KIND_ADD) && !present && (evict_r || free_fnd_r);
  assign ram_we   = do_ins;

  // Next table state
  always_comb begin
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    hand_nxt  = hand_r;
    count_nxt = count_r;
    if (state_r == ST_SWEEP) begin
      hand_nxt = hand_next;
      if (cur_valid && cur_ref) begin
        ref_nxt[hand_r] = 1'b0;
      end
    end
    if (commit) begin
      case (kind_r)
        KIND_TOUCH: begin
          if (hit_r) begin
            ref_nxt[pos_r] = 1'b1;
          end
        end
        KIND_ADD: begin
          if (evict_r) begin
            valid_nxt[vic_r] = 1'b0;
            ref_nxt[vic_r]   = 1'b0;
            count_nxt        = count_nxt - CW'(1);
          end
          if (do_ins) begin
            valid_nxt[ins_idx] = 1'b1;
            ref_nxt[ins_idx]   = 1'b1;
            count_nxt          = count_nxt + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = (pop_kind == KIND_NOP) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if ((kind_r == KIND_ADD) && need_evict) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_stop) begin
          state_nxt = ST_VREAD;
        end
      end
      ST_VREAD: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      ref_r       <= '0;
      hand_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      ref_r   <= ref_nxt;
      hand_r  <= hand_nxt;
      count_r <= count_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-transaction working registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      key_r      <= q_rdata[KEY_BITS-1:0];
      kind_r     <= pop_kind;
      scan_cnt_r <= '0;
      hit_r      <= 1'b0;
      free_fnd_r <= 1'b0;
      evict_r    <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      scan_cnt_r <= scan_cnt_r + CW'(1);
      if (scan_live) begin
        if (!hit_r && chk_match) begin
          hit_r <= 1'b1;
          pos_r <= chk_idx;
        end
        if (!free_fnd_r && chk_free) begin
          free_fnd_r <= 1'b1;
          free_idx_r <= chk_idx;
        end
      end
    end
    if ((state_r == ST_SWEEP) && sweep_stop) begin
      evict_r <= 1'b1;
      vic_r   <= hand_r;
    end
    if (state_r == ST_VREAD) begin
      vkey_r <= ram_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_evicted_r    <= evict_r;
      out_victim_key_r <= evict_r ? vkey_r : '0;
      out_hit_r        <= hit_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_evicted    = out_evicted_r;
  assign out_victim_key = out_victim_key_r;
  assign out_hit        = out_hit_r;

endmodule
